FILE: rtl/ufr_pkg.sv
package ufr_pkg;

  // Longest payload that the header length byte may declare.
  localparam logic [7:0] MAX_PAYLOAD = 8'd121;

  // Fixed frame bytes.
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] MARK_BYTE  = 8'hFF;
  localparam logic [7:0] PAD_BYTE   = 8'h00;
  localparam logic [7:0] TRAIL_BYTE = 8'h55;

  // Byte positions within the output sequence of one item.
  localparam logic [2:0] POS_SYNC   = 3'd0;
  localparam logic [2:0] POS_MARK   = 3'd1;
  localparam logic [2:0] POS_CNT_HI = 3'd2;
  localparam logic [2:0] POS_CNT_LO = 3'd3;
  localparam logic [2:0] POS_PAD    = 3'd4;
  localparam logic [2:0] POS_LEN    = 3'd5;
  localparam logic [2:0] POS_DATA   = 3'd6;
  localparam logic [2:0] POS_TRAIL  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] frame_len;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } res_t;

  // Item as held by the input stage, with its header values settled.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  len;
    logic [15:0] cnt;
    logic        last;
    logic        zero;
  } held_t;

  // Input stage toward the byte selector.
  typedef struct packed {
    logic       valid;
    logic [2:0] pos;
    held_t      held;
  } stage_t;

  // Byte selector back toward the input stage.
  typedef struct packed {
    logic take;
    logic done;
  } step_t;

endpackage

FILE: rtl/ufr_item_reg.sv
module ufr_item_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ufr_pkg::item_t  item,
  input  ufr_pkg::step_t  step,
  output ufr_pkg::stage_t stage
);

  logic           valid;
  logic [2:0]     pos;
  ufr_pkg::held_t held;
  logic [15:0]    cnt;
  logic [7:0]     len_ext;
  logic [7:0]     len_sat;

  // A new item enters when the stage is empty or its final byte moves on now.
  assign item_ready = !valid || step.done;

  // Saturate the declared length for the header.
  assign len_ext = {1'b0, item.frame_len};
  assign len_sat = (len_ext > ufr_pkg::MAX_PAYLOAD) ? ufr_pkg::MAX_PAYLOAD : len_ext;

  // Control state and the message counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= ufr_pkg::POS_SYNC;
      cnt   <= '0;
    end else if (item_valid && item_ready) begin
      valid <= 1'b1;
      pos   <= item.first ? ufr_pkg::POS_SYNC : ufr_pkg::POS_DATA;
      if (item.first) begin
        cnt <= cnt + 16'd1;
      end
    end else if (step.done) begin
      valid <= 1'b0;
    end else if (step.take) begin
      pos <= pos + 3'd1;
    end
  end

  // Payload of the held item; the counter value is the one before this frame.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held.data_byte <= item.data_byte;
      held.len       <= len_sat;
      held.cnt       <= cnt;
      held.last      <= item.last;
      held.zero      <= item.first && (len_sat == 8'd0);
    end
  end

  assign stage.valid = valid;
  assign stage.pos   = pos;
  assign stage.held  = held;

endmodule

FILE: rtl/ufr_byte_sel.sv
module ufr_byte_sel (
  input  logic            clk,
  input  logic            rst,
  input  ufr_pkg::stage_t stage,
  output ufr_pkg::step_t  step,
  output logic            res_valid,
  input  logic            res_ready,
  output ufr_pkg::res_t   res
);

  logic          advance;
  logic          final_byte;
  ufr_pkg::res_t sel;

  // The result register takes a byte whenever it is empty or being drained.
  assign advance   = !res_valid || res_ready;
  assign step.take = stage.valid && advance;
  assign step.done = step.take && final_byte;

  // The item ends on the trailer, or on the data byte when no trailer follows.
  assign final_byte = (stage.pos == ufr_pkg::POS_TRAIL) ||
                      ((stage.pos == ufr_pkg::POS_DATA) &&
                       (!stage.held.last || stage.held.zero));

  // Pick the byte for the current position.
  always_comb begin
    sel.out_last = 1'b0;
    unique case (stage.pos)
      ufr_pkg::POS_SYNC:   sel.out_byte = ufr_pkg::SYNC_BYTE;
      ufr_pkg::POS_MARK:   sel.out_byte = ufr_pkg::MARK_BYTE;
      ufr_pkg::POS_CNT_HI: sel.out_byte = stage.held.cnt[15:8];
      ufr_pkg::POS_CNT_LO: sel.out_byte = stage.held.cnt[7:0];
      ufr_pkg::POS_PAD:    sel.out_byte = ufr_pkg::PAD_BYTE;
      ufr_pkg::POS_LEN:    sel.out_byte = stage.held.len;
      ufr_pkg::POS_DATA: begin
        // A zero-length frame puts its trailer where the data byte would be.
        sel.out_byte = stage.held.zero ? ufr_pkg::TRAIL_BYTE : stage.held.data_byte;
        sel.out_last = stage.held.zero;
      end
      ufr_pkg::POS_TRAIL: begin
        sel.out_byte = ufr_pkg::TRAIL_BYTE;
        sel.out_last = 1'b1;
      end
      default: sel.out_byte = ufr_pkg::PAD_BYTE;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.take) begin
      res <= sel;
    end
  end

endmodule

FILE: rtl/uart_message_framer_unit.sv
// Message framer: each accepted item yields one to eight output bytes, one byte per
// cycle through a registered output while res_ready does not stall it. A first item
// sends the six-byte header (0x55, 0xFF, counter high, counter low, 0x00, length
// saturated to 121), then its data byte, or only the trailer 0x55 when the length is
// zero; a last item adds the trailer 0x55 with out_last set. Payload items pass at one
// per cycle when the output does not stall; a first item has 7 or 8 output bytes, any
// other 1 or 2, and the position counter of the input stage steps through them. The
// 16-bit frame counter starts at zero after reset and wraps.
module uart_message_framer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  ufr_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output ufr_pkg::res_t  res
);

  ufr_pkg::stage_t stage;
  ufr_pkg::step_t  step;

  ufr_item_reg u_item_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .step       (step),
    .stage      (stage)
  );

  ufr_byte_sel u_byte_sel (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .step      (step),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

FILE: rtl/ufr_checker.sv
module ufr_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input ufr_pkg::item_t item,
  input logic           res_valid,
  input logic           res_ready,
  input ufr_pkg::res_t  res
);

  // A stalled result holds until its transfer.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // The frame end marker only ever rides on the trailer byte.
  a_trailer: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.out_last |-> res.out_byte == ufr_pkg::TRAIL_BYTE)
    else $error("out_last on a byte other than the trailer");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // When the output register is empty, the block refuses a new item only while a held
  // item is loading its next byte into that register.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !item_ready |=> res_valid)
    else $error("block stalled with nothing to deliver");

endmodule

bind uart_message_framer_unit ufr_checker u_ufr_checker (.*);

FILE: tb/uart_message_framer_unit_tb.sv
module uart_message_framer_unit_tb;

  // Frame bytes and limits, kept apart from the design's own constants.
  localparam logic [7:0] FRAME_SYNC  = 8'h55;
  localparam logic [7:0] FRAME_MARK  = 8'hFF;
  localparam logic [7:0] FRAME_PAD   = 8'h00;
  localparam logic [7:0] FRAME_TRAIL = 8'h55;
  localparam logic [6:0] LEN_CAP     = 7'd121;
  localparam int MAX_GAP       = 8;
  localparam int STALL_LIMIT   = 500;
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MISMATCH_SHOW = 10;

  // Predicts the framed byte stream and checks each byte that the block sends.
  class frame_scoreboard;
    ufr_pkg::res_t pending_bytes[$];
    logic [15:0]   frame_count;
    int unsigned   mismatches;

    function new();
      frame_count = '0;
      mismatches  = 0;
    endfunction

    function void add_byte(logic [7:0] b, logic is_last);
      ufr_pkg::res_t r;
      r.out_byte = b;
      r.out_last = is_last;
      pending_bytes.push_back(r);
    endfunction

    // Works out the bytes caused by one accepted item.
    function void note_item(ufr_pkg::item_t it);
      logic [6:0] len;
      len = it.frame_len;
      if (it.first) begin
        if (len > LEN_CAP) len = LEN_CAP;
        add_byte(FRAME_SYNC, 1'b0);
        add_byte(FRAME_MARK, 1'b0);
        add_byte(frame_count[15:8], 1'b0);
        add_byte(frame_count[7:0], 1'b0);
        add_byte(FRAME_PAD, 1'b0);
        add_byte({1'b0, len}, 1'b0);
        frame_count = frame_count + 16'd1;
        // A zero-length frame ends right after its header.
        if (len == '0) begin
          add_byte(FRAME_TRAIL, 1'b1);
          return;
        end
      end
      add_byte(it.data_byte, 1'b0);
      if (it.last) add_byte(FRAME_TRAIL, 1'b1);
    endfunction

    // Compares one received byte with the oldest prediction.
    function void check_result(ufr_pkg::res_t got);
      ufr_pkg::res_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOW)
          $display("Unexpected byte: out_byte=%h out_last=%b", got.out_byte, got.out_last);
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.out_last !== want.out_last) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOW)
          $display("Mismatch: expected out_byte=%h out_last=%b, got out_byte=%h out_last=%b",
                   want.out_byte, want.out_last, got.out_byte, got.out_last);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           item_valid;
  logic           item_ready;
  ufr_pkg::item_t item;
  logic           res_valid;
  logic           res_ready;
  ufr_pkg::res_t  res;

  frame_scoreboard sb;
  bit no_idle = 1'b0;
  int stall_cycles = 0;

  uart_message_framer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic ufr_pkg::item_t make_item(logic [7:0] d, logic [6:0] l, logic f,
                                               logic la);
    ufr_pkg::item_t it;
    it.data_byte = d;
    it.frame_len = l;
    it.first     = f;
    it.last      = la;
    return it;
  endfunction

  // Sends one item after a random gap; entered and left at a falling edge.
  task automatic send_item(input ufr_pkg::item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
  endtask

  // Sends a frame: mostly well formed, sometimes with a wrong payload count.
  task automatic send_frame(input bit broken, output int sent);
    logic [6:0] len;
    int count;
    len = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 6));
    if (broken) count = $urandom_range(1, 6);
    else count = (len > LEN_CAP) ? int'(LEN_CAP) : int'(len);
    if (count == 0) begin
      send_item(make_item(8'($urandom), len, 1'b1, 1'($urandom)));
      sent = 1;
    end else begin
      send_item(make_item(8'($urandom), len, 1'b1, count == 1));
      for (int i = 1; i < count; i++)
        send_item(make_item(8'($urandom), 7'($urandom), 1'b0, i == count - 1));
      sent = count;
    end
  endtask

  // Random mix of frames and loose items.
  task automatic random_items(input int how_many);
    int kind;
    int sent;
    for (int n = 0; n < how_many; ) begin
      kind = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 5) == 0);
      if (kind <= 6) begin
        send_frame(1'b0, sent);
        n += sent;
      end else if (kind <= 8) begin
        send_frame(1'b1, sent);
        n += sent;
      end else begin
        send_item(make_item(8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom)));
        n++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: takes each byte after a random stall and checks it.
  initial begin
    int stall;
    res_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      sb.check_result(res);
      @(negedge clk);
    end
  end

  // Main sequence: reset, directed items, random items, drain.
  initial begin
    sb = new();
    item_valid = 1'b0;
    item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // An ordinary three-byte frame with extreme data values.
    send_item(make_item(8'h00, 7'd3, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 7'd0, 1'b0, 1'b0));
    send_item(make_item(8'hA5, 7'd64, 1'b0, 1'b1));
    // Zero-length frames: data and last are ignored.
    send_item(make_item(8'h3C, 7'd0, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 7'd0, 1'b1, 1'b1));
    // Single-byte frame with first and last on the same item.
    send_item(make_item(8'h5A, 7'd1, 1'b1, 1'b1));
    // Largest legal length; the payload count is not enforced.
    send_item(make_item(8'h81, 7'd121, 1'b1, 1'b1));
    // Lengths above the cap saturate in the header.
    send_item(make_item(8'h7E, 7'd122, 1'b1, 1'b0));
    send_item(make_item(8'h7E, 7'd127, 1'b0, 1'b1));
    send_item(make_item(8'h01, 7'd127, 1'b1, 1'b1));
    // Payload items with no frame open pass without a header.
    send_item(make_item(8'h33, 7'd5, 1'b0, 1'b0));
    send_item(make_item(8'hCC, 7'd127, 1'b0, 1'b1));
    send_item(make_item(8'h00, 7'd0, 1'b0, 1'b1));
    // A new first item arrives while a frame is still open.
    send_item(make_item(8'h96, 7'd2, 1'b1, 1'b0));
    send_item(make_item(8'h69, 7'd5, 1'b1, 1'b0));
    send_item(make_item(8'hF0, 7'd42, 1'b0, 1'b0));
    send_item(make_item(8'h0F, 7'd85, 1'b0, 1'b1));

    random_items(RANDOM_ITEMS / 2);
    random_items(RANDOM_ITEMS / 2);

    item_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_bytes.size() != 0) begin
      $display("Bytes never received: %0d", sb.pending_bytes.size());
      sb.mismatches += sb.pending_bytes.size();
    end
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
